// File: src/swhsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swhsd_pkg;

  localparam int unsigned EDGES_PER_FRAME = 42;
  localparam int unsigned DATA_W          = 40;
  localparam int unsigned FIRST_DATA_EDGE = EDGES_PER_FRAME - DATA_W;
  localparam int unsigned EDGE_W          = $clog2(EDGES_PER_FRAME + 1);
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned THR_W           = 10;
  localparam int unsigned TICK_W          = 8;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 10;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_EDGE  = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_CSUM    = 2'd1;
  localparam logic [1:0] STS_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd2;

  localparam logic              SENSOR_KIND_RST   = 1'b1;
  localparam logic [THR_W-1:0]  BIT_THRESHOLD_RST = 10'd100;
  localparam logic [TICK_W-1:0] TIMEOUT_LIMIT_RST = 8'd5;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] time_us;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
  } result_t;

  function automatic result_t frame_result(input logic [DATA_W-1:0] bits, input logic kind);
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  b4;
    logic [7:0]  sum;
    logic [15:0] rawt;
    result_t     r;
    b0   = bits[39:32];
    b1   = bits[31:24];
    b2   = bits[23:16];
    b3   = bits[15:8];
    b4   = bits[7:0];
    sum  = b0 + b1 + b2 + b3;
    rawt = {b2, b3};
    r    = '0;
    if (sum != b4) begin
      r.status = STS_CSUM;
    end else if (!kind) begin
      r.status      = STS_OK;
      r.humidity    = {8'h00, b0};
      r.temperature = {8'h00, b2};
    end else begin
      r.status   = STS_OK;
      r.humidity = {b0, b1};
      if (rawt[15]) begin
        r.temperature = 16'h0000 - {1'b0, rawt[14:0]};
      end else begin
        r.temperature = rawt;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/swhsd_ingress.sv
`timescale 1ns / 1ps
`default_nettype none

module swhsd_ingress import swhsd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [TIME_W-1:0] time_us_i,
  input  wire logic              pop_i,
  output logic                   item_valid_o,
  output item_t                  item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  in_fire;

  assign in_ready_o = !valid_q || pop_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.action  <= action_i;
      item_q.time_us <= time_us_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// File: src/swhsd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module swhsd_decode import swhsd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  item_valid_i,
  input  wire item_t                 item_i,
  input  wire logic                  slot_free_i,
  output logic                       pop_o,
  output logic                       res_valid_o,
  output result_t                    res_o
);

  logic              sensor_kind_q;
  logic [THR_W-1:0]  bit_threshold_q;
  logic [TICK_W-1:0] timeout_limit_q;

  logic              busy_q;
  logic              busy_d;
  logic              armed_q;
  logic              armed_d;
  logic [EDGE_W-1:0] edge_count_q;
  logic [EDGE_W-1:0] edge_count_d;
  logic [TIME_W-1:0] last_time_q;
  logic [TIME_W-1:0] last_time_d;
  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;
  logic [TICK_W-1:0] tick_q;
  logic [TICK_W-1:0] tick_d;

  logic              fire;
  logic [TIME_W-1:0] interval;
  logic              bit_val;
  logic [EDGE_W-1:0] edge_inc;

  assign fire     = item_valid_i && slot_free_i;
  assign pop_o    = fire;
  assign interval = item_i.time_us - last_time_q;
  assign bit_val  = interval > {{(TIME_W-THR_W){1'b0}}, bit_threshold_q};
  assign edge_inc = edge_count_q + EDGE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_kind_q   <= SENSOR_KIND_RST;
      bit_threshold_q <= BIT_THRESHOLD_RST;
      timeout_limit_q <= TIMEOUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SENSOR_KIND:   sensor_kind_q   <= cfg_wdata_i[0];
        REG_BIT_THRESHOLD: bit_threshold_q <= cfg_wdata_i[THR_W-1:0];
        REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_d       = busy_q;
    armed_d      = armed_q;
    edge_count_d = edge_count_q;
    last_time_d  = last_time_q;
    data_d       = data_q;
    tick_d       = tick_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (fire) begin
      unique case (item_i.action)
        ACT_START: begin
          busy_d       = 1'b1;
          armed_d      = 1'b0;
          tick_d       = '0;
          edge_count_d = '0;
        end
        ACT_TICK: begin
          if (busy_q) begin
            if (tick_q != '1) begin
              tick_d = tick_q + TICK_W'(1);
            end
            armed_d      = 1'b1;
            edge_count_d = '0;
            data_d       = '0;
            last_time_d  = item_i.time_us;
            if (tick_d > timeout_limit_q) begin
              busy_d      = 1'b0;
              armed_d     = 1'b0;
              res_valid_o = 1'b1;
              res_o.status = STS_TIMEOUT;
            end
          end
        end
        ACT_EDGE: begin
          if (armed_q) begin
            last_time_d = item_i.time_us;
            if (edge_count_q >= EDGE_W'(FIRST_DATA_EDGE)) begin
              data_d = {data_q[DATA_W-2:0], bit_val};
            end
            edge_count_d = edge_inc;
            if (edge_inc >= EDGE_W'(EDGES_PER_FRAME)) begin
              res_valid_o  = 1'b1;
              res_o        = frame_result(data_d, sensor_kind_q);
              busy_d       = 1'b0;
              armed_d      = 1'b0;
              edge_count_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      armed_q      <= 1'b0;
      edge_count_q <= '0;
      last_time_q  <= '0;
      data_q       <= '0;
      tick_q       <= '0;
    end else begin
      busy_q       <= busy_d;
      armed_q      <= armed_d;
      edge_count_q <= edge_count_d;
      last_time_q  <= last_time_d;
      data_q       <= data_d;
      tick_q       <= tick_d;
    end
  end

  a_armed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> busy_q)
    else $error("capture armed while not busy");

  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_count_q < EDGE_W'(EDGES_PER_FRAME))
    else $error("edge count beyond frame length");

  a_edge_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_count_q != '0) |-> armed_q)
    else $error("edges counted without capture armed");

  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> slot_free_i)
    else $error("result produced with output slot occupied");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !busy_q)
    else $error("still busy after a result");

endmodule

`default_nettype wire

// File: src/swhsd_egress.sv
`timescale 1ns / 1ps
`default_nettype none

module swhsd_egress import swhsd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  input  wire result_t       res_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         status_o,
  output logic [15:0]        humidity_o,
  output logic signed [15:0] temperature_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = res_q.status;
  assign humidity_o    = res_q.humidity;
  assign temperature_o = res_q.temperature;

endmodule

`default_nettype wire

// File: src/single_wire_humidity_sensor_decoder_core.sv
// a transaction is held in the input register, decoded, and its result is registered in the result register
// throughput: one event per cycle while results are taken, set by the input register and the result register
// a result not taken stalls the decoder; the input register then holds one more transaction
// each event: a 32-bit subtract and compare, at frame end also the checksum and sign fix
// reset: asynchronous, active low; clears busy, capture, counters, timestamp and data bits
// configuration returns to DHT22 format, threshold 100 us and timeout limit 5
`timescale 1ns / 1ps
`default_nettype none

module single_wire_humidity_sensor_decoder_core import swhsd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            action_i,
  input  wire logic [TIME_W-1:0]     time_us_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [1:0]                 status_o,
  output logic [15:0]                humidity_o,
  output logic signed [15:0]         temperature_o
);

  logic    pop;
  logic    item_valid;
  item_t   item;
  logic    slot_free;
  logic    res_valid;
  result_t res;

  swhsd_ingress u_ingress (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .time_us_i    (time_us_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  swhsd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .slot_free_i  (slot_free),
    .pop_o        (pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  swhsd_egress u_egress (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .slot_free_o   (slot_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .humidity_o    (humidity_o),
    .temperature_o (temperature_o)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb import swhsd_pkg::*;;

  localparam logic [1:0]  ACT_SPARE        = 2'd3;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES      = 8;
  localparam int unsigned ITEM_TARGET      = 900;

  typedef struct packed {
    bit          frame;
    logic [1:0]  act;   // frames: ACT_START opens with a start, ACT_TICK re-arms only
    logic [5:0]  reps;  // events, or edges of a frame
    logic [31:0] t;
    logic [39:0] bits;
    bit          pinned;
    result_t     res;
  } step_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            action_i    = ACT_START;
  logic [TIME_W-1:0]     time_us_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic [15:0]           humidity_o;
  logic signed [15:0]    temperature_o;

  // decoder mirror
  logic              cfg_kind  = SENSOR_KIND_RST;
  logic [THR_W-1:0]  cfg_thr   = BIT_THRESHOLD_RST;
  logic [TICK_W-1:0] cfg_limit = TIMEOUT_LIMIT_RST;
  bit                dec_busy  = 1'b0;
  bit                dec_armed = 1'b0;
  logic [5:0]        dec_edges = '0;
  logic [31:0]       dec_last  = '0;
  logic [39:0]       dec_bits  = '0;
  logic [7:0]        dec_ticks = '0;

  result_t     readings_due [$];
  result_t     row_result    = '0;
  bit          row_pinned    = 1'b0;
  bit          src_quiet     = 1'b0;
  bit          sink_quiet    = 1'b0;
  bit          sink_hold     = 1'b0;
  int unsigned events_sent   = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  single_wire_humidity_sensor_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .time_us_i     (time_us_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .humidity_o    (humidity_o),
    .temperature_o (temperature_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void decode_event(input logic [1:0] act, input logic [31:0] t,
                                       output bit emits, output result_t r);
    logic [31:0] span;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [15:0] rawt;
    emits = 1'b0;
    r     = '0;
    case (act)
      ACT_START: begin
        dec_busy  = 1'b1;
        dec_armed = 1'b0;
        dec_ticks = '0;
        dec_edges = '0;
      end
      ACT_TICK: begin
        if (dec_busy) begin
          if (dec_ticks != 8'hFF) dec_ticks = dec_ticks + 8'd1;
          dec_armed = 1'b1;
          dec_edges = '0;
          dec_bits  = '0;
          dec_last  = t;
          if (dec_ticks > cfg_limit) begin
            dec_busy  = 1'b0;
            dec_armed = 1'b0;
            emits     = 1'b1;
            r.status  = STS_TIMEOUT;
          end
        end
      end
      ACT_EDGE: begin
        if (dec_armed) begin
          span     = t - dec_last;
          dec_last = t;
          if (dec_edges >= FIRST_DATA_EDGE) dec_bits = {dec_bits[38:0], span > cfg_thr};
          dec_edges = dec_edges + 6'd1;
          if (dec_edges >= EDGES_PER_FRAME) begin
            {b0, b1, b2, b3, b4} = dec_bits;
            rawt  = {b2, b3};
            emits = 1'b1;
            if (8'(b0 + b1 + b2 + b3) != b4) begin
              r.status = STS_CSUM;
            end else if (!cfg_kind) begin
              r.status      = STS_OK;
              r.humidity    = {8'h00, b0};
              r.temperature = {8'h00, b2};
            end else begin
              r.status      = STS_OK;
              r.humidity    = {b0, b1};
              r.temperature = rawt[15] ? 16'h0000 - {1'b0, rawt[14:0]} : rawt;
            end
            dec_armed = 1'b0;
            dec_busy  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [39:0] pick_frame();
    logic [7:0] b0, b1, b2, b3, b4;
    b0 = 8'($urandom());
    b1 = 8'($urandom());
    b2 = 8'($urandom());
    b3 = 8'($urandom());
    b4 = ($urandom_range(0, 3) != 0) ? 8'(b0 + b1 + b2 + b3) : 8'($urandom());
    return {b0, b1, b2, b3, b4};
  endfunction

  function automatic logic [31:0] pick_time();
    return ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + 32'($urandom_range(0, 4095))
                                       : $urandom();
  endfunction

  task automatic put_event(input logic [1:0] act, input logic [31:0] t);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    time_us_i  = t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [39:0] bits, input logic [1:0] lead,
                            input int unsigned n_edges, input logic [31:0] t0, input bit exact);
    logic [31:0] now;
    int unsigned gap_us;
    int unsigned k;
    bit          b;
    now = t0;
    if (lead == ACT_START) put_event(ACT_START, now);
    put_event(ACT_TICK, now);
    for (k = 0; k < n_edges; k++) begin
      if (k < FIRST_DATA_EDGE) begin
        gap_us = exact ? 80 : $urandom_range(20, 200);
      end else begin
        b = bits[39 - (k - FIRST_DATA_EDGE)];
        if (exact) gap_us = b ? cfg_thr + 1 : cfg_thr;
        else gap_us = b ? cfg_thr + 1 + $urandom_range(0, 150) : $urandom_range(0, cfg_thr);
      end
      now = now + gap_us;
      put_event(ACT_EDGE, now);
    end
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (readings_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    case (idx)
      REG_SENSOR_KIND:   cfg_kind  = val[0];
      REG_BIT_THRESHOLD: cfg_thr   = val[THR_W-1:0];
      REG_TIMEOUT_LIMIT: cfg_limit = val[TICK_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = events_sent + n;
    while (events_sent < stop_at) begin
      src_quiet  = ($urandom_range(0, 4) == 0);
      sink_quiet = ($urandom_range(0, 4) == 0);
      pick       = $urandom_range(0, 9);
      if (pick <= 5) begin
        send_frame(pick_frame(), ACT_START, EDGES_PER_FRAME, pick_time(), 1'b0);
      end else if (pick == 6) begin
        // cut short, then re-armed by a tick
        send_frame(pick_frame(), ACT_START, $urandom_range(0, EDGES_PER_FRAME - 1),
                   pick_time(), 1'b0);
        send_frame(pick_frame(), ACT_TICK, EDGES_PER_FRAME, pick_time(), 1'b0);
      end else if (pick == 7) begin
        put_event(ACT_START, pick_time());
        repeat ($urandom_range(1, 10)) put_event(ACT_TICK, pick_time());
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) put_event(2'($urandom_range(0, 3)), $urandom());
      end else begin
        put_event(ACT_START, pick_time());
        repeat ($urandom_range(0, 4)) put_event(ACT_EDGE, $urandom());
        send_frame(pick_frame(), ACT_TICK, EDGES_PER_FRAME, pick_time(), 1'b0);
      end
    end
  endtask

  always @(posedge clk_i) begin : watch_channels
    result_t want;
    result_t made;
    bit      emits;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (readings_due.size() == 0) begin
          mismatches++;
          $display("%0t: reading with none outstanding: status %0d humidity %0d temperature %0d",
                   $time, status_o, humidity_o, temperature_o);
        end else begin
          want = readings_due.pop_front();
          if (status_o !== want.status || humidity_o !== want.humidity ||
              temperature_o !== want.temperature) begin
            mismatches++;
            $display("%0t: mismatch: expected status %0d humidity %0d temperature %0d",
                     $time, want.status, want.humidity, want.temperature);
            $display("%0t:           actual   status %0d humidity %0d temperature %0d",
                     $time, status_o, humidity_o, temperature_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        events_sent++;
        decode_event(action_i, time_us_i, emits, made);
        if (emits) begin
          readings_due.push_back(row_pinned ? row_result : made);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        out_ready_i = 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      stall = sink_quiet ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin : stimulus
    step_row_t   plan [26];
    int unsigned i;
    int unsigned k;

    plan[0]  = '{1'b0, ACT_TICK,  6'd1,  32'h0000_1000, 40'h0, 1'b0, '0};
    plan[1]  = '{1'b0, ACT_EDGE,  6'd1,  32'h0000_1100, 40'h0, 1'b0, '0};
    plan[2]  = '{1'b0, ACT_SPARE, 6'd1,  32'hFFFF_FFFF, 40'h0, 1'b0, '0};
    plan[3]  = '{1'b1, ACT_START, 6'd42, 32'h0012_3400, 40'h02_8C_01_5F_EE, 1'b1,
                 '{STS_OK, 16'h028C, 16'sh015F}};
    plan[4]  = '{1'b1, ACT_START, 6'd42, 32'h0020_0000, 40'h01_F4_80_65_DA, 1'b1,
                 '{STS_OK, 16'h01F4, -16'sd101}};
    plan[5]  = '{1'b1, ACT_START, 6'd42, 32'h0030_0000, 40'h01_F4_80_65_DB, 1'b1,
                 '{STS_CSUM, 16'h0000, 16'sh0000}};
    plan[6]  = '{1'b1, ACT_START, 6'd42, 32'h0000_0000, 40'h00_00_00_00_00, 1'b1,
                 '{STS_OK, 16'h0000, 16'sh0000}};
    plan[7]  = '{1'b1, ACT_START, 6'd42, 32'hFFFF_FFFF, 40'hFF_FF_FF_FF_FF, 1'b1,
                 '{STS_CSUM, 16'h0000, 16'sh0000}};
    plan[8]  = '{1'b1, ACT_START, 6'd42, 32'hFFFF_FF00, 40'hFF_FF_FF_FF_FC, 1'b1,
                 '{STS_OK, 16'hFFFF, -16'sd32767}};
    plan[9]  = '{1'b1, ACT_START, 6'd42, 32'h7FFF_FFFF, 40'h00_00_80_00_80, 1'b0, '0};
    plan[10] = '{1'b1, ACT_START, 6'd42, 32'h8000_0000, 40'h7F_FF_7F_FF_FC, 1'b1,
                 '{STS_OK, 16'h7FFF, 16'sh7FFF}};
    plan[11] = '{1'b0, ACT_START, 6'd1,  32'h0100_0000, 40'h0, 1'b0, '0};
    plan[12] = '{1'b0, ACT_TICK,  6'd5,  32'h0100_4E20, 40'h0, 1'b0, '0};
    plan[13] = '{1'b0, ACT_TICK,  6'd1,  32'h0102_0000, 40'h0, 1'b1,
                 '{STS_TIMEOUT, 16'h0000, 16'sh0000}};
    plan[14] = '{1'b0, ACT_START, 6'd1,  32'h0200_0000, 40'h0, 1'b0, '0};
    plan[15] = '{1'b0, ACT_TICK,  6'd3,  32'h0200_4E20, 40'h0, 1'b0, '0};
    plan[16] = '{1'b0, ACT_START, 6'd1,  32'h0201_0000, 40'h0, 1'b0, '0};
    plan[17] = '{1'b0, ACT_TICK,  6'd5,  32'h0201_4E20, 40'h0, 1'b0, '0};
    plan[18] = '{1'b0, ACT_TICK,  6'd1,  32'h0203_0000, 40'h0, 1'b1,
                 '{STS_TIMEOUT, 16'h0000, 16'sh0000}};
    plan[19] = '{1'b0, ACT_TICK,  6'd1,  32'h0300_0000, 40'h0, 1'b0, '0};
    plan[20] = '{1'b0, ACT_EDGE,  6'd1,  32'h0300_0100, 40'h0, 1'b0, '0};
    plan[21] = '{1'b1, ACT_START, 6'd20, 32'h5555_AAAA, 40'hA5_A5_A5_A5_A5, 1'b0, '0};
    plan[22] = '{1'b1, ACT_TICK,  6'd42, 32'h5556_0000, 40'h3C_2D_1E_0F_96, 1'b0, '0};
    plan[23] = '{1'b0, ACT_START, 6'd1,  32'hAAAA_5555, 40'h0, 1'b0, '0};
    plan[24] = '{1'b0, ACT_EDGE,  6'd3,  32'hAAAA_6000, 40'h0, 1'b0, '0};
    plan[25] = '{1'b1, ACT_TICK,  6'd42, 32'hAAAB_0000, 40'h00_01_00_02_03, 1'b0, '0};

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows, reset configuration
    for (i = 0; i < 26; i++) begin
      row_pinned = plan[i].pinned;
      row_result = plan[i].res;
      if (plan[i].frame) begin
        send_frame(plan[i].bits, plan[i].act, plan[i].reps, plan[i].t, 1'b1);
      end else begin
        for (k = 0; k < plan[i].reps; k++) put_event(plan[i].act, plan[i].t + k * 50);
      end
    end
    row_pinned = 1'b0;
    settle();

    // whole-unit format, zero threshold, tick count driven into saturation
    write_reg(REG_SENSOR_KIND, CFG_DATA_W'(0));
    write_reg(REG_BIT_THRESHOLD, CFG_DATA_W'(0));
    write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(255));
    src_quiet = 1'b1;
    put_event(ACT_START, $urandom());
    repeat (260) put_event(ACT_TICK, $urandom());
    src_quiet = 1'b0;
    send_frame(pick_frame(), ACT_TICK, EDGES_PER_FRAME, pick_time(), 1'b0);
    random_traffic(30);
    settle();

    write_reg(REG_SENSOR_KIND, CFG_DATA_W'(1));
    write_reg(REG_BIT_THRESHOLD, CFG_DATA_W'(1023));
    write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(1));
    random_traffic(30);
    settle();

    // back-pressure: timeouts pile up behind a long sink hold-off
    write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(0));
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    sink_hold  = 1'b1;
    repeat (8) begin
      put_event(ACT_START, $urandom());
      put_event(ACT_TICK, $urandom());
    end
    settle();
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    repeat (4) begin
      put_event(ACT_START, $urandom());
      put_event(ACT_TICK, $urandom());
    end
    settle();

    do begin
      write_reg(REG_SENSOR_KIND, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(REG_BIT_THRESHOLD, CFG_DATA_W'($urandom_range(0, 1023)));
      write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'($urandom_range(1, 12)));
      random_traffic(20);
      settle();
    end while (events_sent < ITEM_TARGET);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/swhsd_pkg.sv
src/swhsd_ingress.sv
src/swhsd_decode.sv
src/swhsd_egress.sv
src/single_wire_humidity_sensor_decoder_core.sv
dv/tb.sv
